// ----- hw/rtl/pfs_pkg.sv -----
// ----------------------------------------------------------------------------
// pfs_pkg - shared types for the priority filter sorter
// Entry record held by each sort cell, cell control and sequencer states.
// ----------------------------------------------------------------------------
package pfs_pkg;

  localparam int unsigned Capacity = 16;
  localparam int unsigned TagW     = 8;
  localparam int unsigned PrioW    = 7;

  typedef struct packed {
    logic             valid;
    logic [TagW-1:0]  tag;
    logic [PrioW-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic ins;    // insert the broadcast entry this cycle
    logic shift;  // emission: take the entry of the next cell up
  } cell_ctrl_t;

  typedef enum logic {
    ST_COLLECT,
    ST_EMIT
  } pfs_state_e;

endpackage

// ----- hw/rtl/priority_filter_sorter.sv -----
// ----------------------------------------------------------------------------
// priority_filter_sorter - filter, stable descending sort and emission
// Drops negative priorities, inserts kept entries into a chain of cells in
// descending order and streams them out when the last entry of a list lands.
// ----------------------------------------------------------------------------
//  port group   dir  tdata (low bit up)                      tlast       tuser
//  s_axis_*     in   entry_tag[7:0], priority_req[15:8]      last_entry  -
//  m_axis_*     out  sorted_tag[7:0], sorted_priority[14:8]  run_end     overflow
//
//  Collect: one word per cycle; every cell compares and shifts in parallel.
//  Emission: one word per cycle from cell 0 while m_axis_tready is high, the
//  chain shifting towards it; the first word is offered in the cycle after the
//  last entry is taken, and input is taken again with no gap after the last word.
//  An empty list passes through the emit state before collecting resumes.
//  Input is held off (s_axis_tready low) while a list is being emitted.
//  Reset clears the cells, the overflow flag and the sequencer.
//  Output stalls simply freeze the chain; data is taken straight from cell 0.
// ----------------------------------------------------------------------------
module priority_filter_sorter import pfs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // entry_tag[7:0], priority_req[15:8]
  input  logic        s_axis_tlast,   // last_entry
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // sorted_tag[7:0], sorted_priority[14:8], 0
  output logic        m_axis_tlast,   // run_end
  output logic        m_axis_tuser    // overflow
);

  pfs_state_e state_q, state_d;
  logic       ovf_q, ovf_d;

  entry_t     chain [Capacity];
  logic       after [Capacity];
  logic [Capacity-1:0] valid_vec;
  entry_t     new_entry;
  cell_ctrl_t ctrl;

  logic s_acc, m_acc, keep, full;

  // sign bit of priority_req set: entry dropped
  assign keep  = !s_axis_tdata[15];
  assign full  = chain[Capacity-1].valid;
  assign s_acc = s_axis_tvalid && s_axis_tready;
  assign m_acc = m_axis_tvalid && m_axis_tready;

  always_comb begin
    new_entry       = '0;
    new_entry.valid = 1'b1;
    new_entry.tag   = s_axis_tdata[7:0];
    new_entry.prio  = s_axis_tdata[14:8];
  end

  // --- sequencer: next state -------------------------------------------------
  always_comb begin
    state_d = state_q;
    ovf_d   = ovf_q;
    case (state_q)
      ST_COLLECT: begin
        if (s_acc && keep && full) begin
          ovf_d = 1'b1;
        end
        if (s_acc && s_axis_tlast) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // empty list, or final word taken
        if (!chain[0].valid || (m_acc && m_axis_tlast)) begin
          state_d = ST_COLLECT;
          ovf_d   = 1'b0;
        end
      end
      default: begin
        state_d = ST_COLLECT;
      end
    endcase
  end

  // --- sequencer: outputs ----------------------------------------------------
  always_comb begin
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    ctrl          = '0;
    case (state_q)
      ST_COLLECT: begin
        s_axis_tready = 1'b1;
        ctrl.ins      = s_acc && keep && !full;
      end
      ST_EMIT: begin
        m_axis_tvalid = chain[0].valid;
        ctrl.shift    = m_acc;
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_COLLECT;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      ovf_q   <= ovf_d;
    end
  end

  // --- cell chain ------------------------------------------------------------
  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    entry_t prev_e, next_e;
    logic   prev_after;

    if (i == 0) begin : g_head
      assign prev_e     = '0;
      assign prev_after = 1'b1;
    end else begin : g_body
      assign prev_e     = chain[i-1];
      assign prev_after = after[i-1];
    end

    if (i == Capacity - 1) begin : g_tail
      assign next_e = '0;
    end else begin : g_inner
      assign next_e = chain[i+1];
    end

    pfs_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .new_i        (new_entry),
      .prev_i       (prev_e),
      .prev_after_i (prev_after),
      .next_i       (next_e),
      .entry_o      (chain[i]),
      .after_o      (after[i])
    );

    assign valid_vec[i] = chain[i].valid;
  end

  // --- output word -----------------------------------------------------------
  assign m_axis_tdata = {1'b0, chain[0].prio, chain[0].tag};
  assign m_axis_tlast = chain[0].valid && !chain[1].valid;
  assign m_axis_tuser = ovf_q;

  // --- assertions ------------------------------------------------------------
  // held entries always form an unbroken run from the head
  a_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot({1'b0, valid_vec} + {{Capacity{1'b0}}, 1'b1}))
    else $error("cell chain holds a gap");

  a_no_out_collect: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COLLECT) |-> !m_axis_tvalid)
    else $error("result offered while collecting");

  a_emit_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_acc && !m_axis_tlast) |=> m_axis_tvalid)
    else $error("emission broke off before run end");

  a_run_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_acc && m_axis_tlast) |=> (state_q == ST_COLLECT) && !ovf_q && !chain[0].valid)
    else $error("state not cleared after run end");

endmodule

// ----- hw/rtl/pfs_cell.sv -----
// ----------------------------------------------------------------------------
// pfs_cell - one compare-and-shift cell of the sort chain
// Holds one entry; on insert keeps, takes the new entry or takes its lower
// neighbour's; on emission takes its upper neighbour's.
// ----------------------------------------------------------------------------
module pfs_cell import pfs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  entry_t     new_i,        // broadcast entry (valid ignored)
  input  entry_t     prev_i,       // cell one place nearer the head
  input  logic       prev_after_i, // new entry goes after the previous cell
  input  entry_t     next_i,       // cell one place further from the head
  output entry_t     entry_o,
  output logic       after_o       // new entry goes after this cell
);

  entry_t entry_q, entry_d;

  // equal priority stays ahead: stable order
  assign after_o = entry_q.valid && (entry_q.prio >= new_i.prio);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.shift) begin
      entry_d = next_i;
    end else if (ctrl_i.ins && !after_o) begin
      if (prev_after_i) begin
        entry_d       = new_i;
        entry_d.valid = 1'b1;
      end else begin
        entry_d = prev_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;

endmodule
